// ===== design/bir_pkg.sv =====
`timescale 1ns / 1ps
package bir_pkg;

  localparam int PIX_W     = 24;
  localparam int COORD_W   = 8;
  localparam int IN_SIZE_W = 7;
  localparam int OUT_SIZE_W = 9;
  localparam int PROD_W    = COORD_W + IN_SIZE_W;  // coord * in size

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_IN_WIDTH   = 2'd0;
  localparam logic [1:0] REG_IN_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_OUT_WIDTH  = 2'd2;
  localparam logic [1:0] REG_OUT_HEIGHT = 2'd3;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [COORD_W-1:0]       coord_x;
    logic [COORD_W-1:0]       coord_y;
    logic signed [PIX_W-1:0]  sample_in;
  } req_t;

  typedef struct packed {
    logic signed [PIX_W-1:0]  sample_out;
    logic [COORD_W-1:0]       out_x;
    logic [COORD_W-1:0]       out_y;
    logic                     zero_filled;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_MUL,
    ST_FIN
  } st_t;

endpackage

// ===== design/bir_ram.sv =====
`timescale 1ns / 1ps
module bir_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/bir_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module bir_div #(
  parameter int NW = 31,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [DW:0]   rem;
  logic [DW:0]   rem_sh;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          run;

  assign rem_sh = {rem[DW-1:0], quotient[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (run) begin
      if (rem_sh >= {1'b0, dvs}) begin
        rem      <= rem_sh - {1'b0, dvs};
        quotient <= {quotient[NW-2:0], 1'b1};
      end else begin
        rem      <= rem_sh;
        quotient <= {quotient[NW-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== design/bilinear_image_resizer.sv =====
`timescale 1ns / 1ps
// Loads: a load is written at the edge that takes it, and loads may come back to back.
// A compute request goes through the bit-serial divider, then four frame store reads and
// eight multiplies, before done; a request off the output or source skips ahead (zero_filled).
// Throughput: one compute request at a time; start is taken the cycle done shows.
// Reset: synchronous, active high; sizes go to 64; frame store is not cleared.
// The receiver cannot stall: done is a one-cycle strobe.
module bilinear_image_resizer
  import bir_pkg::*;
#(
  parameter int MAX_IN_WIDTH  = 64,
  parameter int MAX_IN_HEIGHT = 64,
  parameter int MAX_OUT_SIZE  = 256,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        start,
  input  req_t        req,
  output logic        busy,
  // result channel
  output logic        done,
  output res_t        res,
  // APB config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int F     = FRACTION_BITS;
  localparam int DEPTH = MAX_IN_WIDTH * MAX_IN_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_IN_WIDTH);
  localparam int YW    = $clog2(MAX_IN_HEIGHT);
  localparam int NW    = PROD_W + F;          // dividend: coord*size << F
  localparam int BW    = F + 1;               // weight width, holds 2^F
  localparam int PW    = PIX_W + BW;          // product width
  localparam int ACCW  = PIX_W + F + 2;       // accumulators

  // ---------------- config registers ----------------
  logic [IN_SIZE_W-1:0]  in_width, in_height;
  logic [OUT_SIZE_W-1:0] out_width, out_height;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width   <= IN_SIZE_W'(64);
      in_height  <= IN_SIZE_W'(64);
      out_width  <= OUT_SIZE_W'(64);
      out_height <= OUT_SIZE_W'(64);
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_IN_WIDTH:   in_width   <= pwdata[IN_SIZE_W-1:0];
        REG_IN_HEIGHT:  in_height  <= pwdata[IN_SIZE_W-1:0];
        REG_OUT_WIDTH:  out_width  <= pwdata[OUT_SIZE_W-1:0];
        REG_OUT_HEIGHT: out_height <= pwdata[OUT_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_IN_WIDTH:   prdata = 32'(in_width);
      REG_IN_HEIGHT:  prdata = 32'(in_height);
      REG_OUT_WIDTH:  prdata = 32'(out_width);
      REG_OUT_HEIGHT: prdata = 32'(out_height);
      default:        prdata = '0;
    endcase
  end

  // Effective sizes: zero acts as one, large values saturate at the maximum.
  logic [IN_SIZE_W-1:0]  iw, ih;
  logic [OUT_SIZE_W-1:0] ow, oh;

  always_comb begin
    iw = in_width;
    if (in_width == '0) iw = IN_SIZE_W'(1);
    else if (32'(in_width) > MAX_IN_WIDTH) iw = IN_SIZE_W'(MAX_IN_WIDTH);
    ih = in_height;
    if (in_height == '0) ih = IN_SIZE_W'(1);
    else if (32'(in_height) > MAX_IN_HEIGHT) ih = IN_SIZE_W'(MAX_IN_HEIGHT);
    ow = out_width;
    if (out_width == '0) ow = OUT_SIZE_W'(1);
    else if (32'(out_width) > MAX_OUT_SIZE) ow = OUT_SIZE_W'(MAX_OUT_SIZE);
    oh = out_height;
    if (out_height == '0) oh = OUT_SIZE_W'(1);
    else if (32'(out_height) > MAX_OUT_SIZE) oh = OUT_SIZE_W'(MAX_OUT_SIZE);
  end

  // ---------------- request decode ----------------
  logic accept, load_ok, req_out_range;
  assign accept        = start && !busy;
  assign load_ok       = (req.coord_x < 8'(iw)) && (req.coord_y < 8'(ih));
  assign req_out_range = (9'(req.coord_x) >= ow) || (9'(req.coord_y) >= oh);

  // source position scaled by 2^F; the divide yields integer part and weight at once
  logic [NW-1:0] num_x, num_y, quo_x, quo_y;
  logic          div_go, div_done, div_done_y;

  assign num_x = {PROD_W'(req.coord_x) * PROD_W'(iw), F'(0)};
  assign num_y = {PROD_W'(req.coord_y) * PROD_W'(ih), F'(0)};

  bir_div #(.NW(NW), .DW(OUT_SIZE_W)) u_div_x (
    .clk(clk), .rst(rst), .start(div_go), .dividend(num_x), .divisor(ow),
    .done(div_done), .quotient(quo_x)
  );

  bir_div #(.NW(NW), .DW(OUT_SIZE_W)) u_div_y (
    .clk(clk), .rst(rst), .start(div_go), .dividend(num_y), .divisor(oh),
    .done(div_done_y), .quotient(quo_y)
  );

  // neighbor square must lie inside the source image
  logic edge_fail;
  assign edge_fail = (quo_x[NW-1:F] + 1'b1 >= PROD_W'(iw)) ||
                     (quo_y[NW-1:F] + 1'b1 >= PROD_W'(ih));

  // ---------------- sequencer ----------------
  st_t state, state_next;
  logic [3:0] cnt;
  logic       div_fin;

  assign div_fin = div_done && div_done_y;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && req.action == ACT_COMPUTE) begin
          state_next = req_out_range ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_fin) state_next = edge_fail ? ST_FIN : ST_READ;
      end
      ST_READ: if (cnt == 4'd4) state_next = ST_MUL;
      ST_MUL:  if (cnt == 4'd8) state_next = ST_FIN;
      ST_FIN:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state != ST_IDLE);
    div_go = 1'b0;
    if (state == ST_IDLE && accept && req.action == ACT_COMPUTE && !req_out_range) begin
      div_go = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state_next == state) ? cnt + 1'b1 : '0;
    end
  end

  // ---------------- frame store ----------------
  logic [XW-1:0]    ix;
  logic [YW-1:0]    iy;
  logic [F-1:0]     u, t;
  logic [AW-1:0]    mem_addr;
  logic             mem_we;
  logic [PIX_W-1:0] mem_rdata;

  assign mem_we = (state == ST_IDLE) && accept && req.action == ACT_LOAD && load_ok;

  always_comb begin
    if (state == ST_IDLE) begin
      mem_addr = AW'(32'(req.coord_y) * MAX_IN_WIDTH + 32'(req.coord_x));
    end else begin
      // p00, p10, p01, p11 in counter order
      mem_addr = AW'((32'(iy) + 32'(cnt[1])) * MAX_IN_WIDTH + 32'(ix) + 32'(cnt[0]));
    end
  end

  bir_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_frame (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(req.sample_in), .rdata(mem_rdata)
  );

  // request context and pixel capture
  logic [COORD_W-1:0] rx, ry;
  logic               zf;
  logic [PIX_W-1:0]   pix [4];
  logic [1:0]         pix_idx;

  assign pix_idx = 2'(cnt - 1'b1);

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      rx <= req.coord_x;
      ry <= req.coord_y;
      zf <= 1'b1;
    end
    if (state == ST_DIV && div_fin) begin
      ix <= quo_x[F +: XW];
      iy <= quo_y[F +: YW];
      u  <= quo_x[F-1:0];
      t  <= quo_y[F-1:0];
      zf <= edge_fail;
    end
    if (state == ST_READ && cnt != 4'd0) begin
      // bias to unsigned: flip sign bit
      pix[pix_idx] <= mem_rdata ^ {1'b1, (PIX_W-1)'(0)};
    end
  end

  // ---------------- blend: one multiply per cycle ----------------
  logic [BW-1:0]    wu, wt, u1, t1, opb;
  logic [PIX_W-1:0] opa;
  logic [PW-1:0]    prod;
  logic [2:0]       prod_tag;
  logic [ACCW-1:0]  acc [4];   // a, b, hi, lo

  assign u1 = {1'b0, u};
  assign t1 = {1'b0, t};
  assign wu = {1'b1, F'(0)} - u1;
  assign wt = {1'b1, F'(0)} - t1;

  always_comb begin
    case (cnt[2:0])
      3'd0: begin opa = pix[0]; opb = wu; end
      3'd1: begin opa = pix[1]; opb = u1; end
      3'd2: begin opa = pix[2]; opb = wu; end
      3'd3: begin opa = pix[3]; opb = u1; end
      3'd4: begin opa = acc[0][F +: PIX_W]; opb = wt; end
      3'd5: begin opa = acc[1][F +: PIX_W]; opb = t1; end
      3'd6: begin opa = PIX_W'(acc[0][F-1:0]); opb = wt; end
      3'd7: begin opa = PIX_W'(acc[1][F-1:0]); opb = t1; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod     <= PW'(opa) * PW'(opb);
    prod_tag <= cnt[2:0];
    if (state == ST_READ) begin
      acc[0] <= '0;
      acc[1] <= '0;
      acc[2] <= '0;
      acc[3] <= ACCW'(1) << (2 * F - 1);   // rounding half
    end else if (state == ST_MUL && cnt != 4'd0) begin
      acc[prod_tag[2:1]] <= acc[prod_tag[2:1]] + ACCW'(prod);
    end
  end

  logic [ACCW-1:0] blend;
  assign blend = acc[2] + (acc[3] >> F);

  // ---------------- result ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN) begin
      res.out_x       <= rx;
      res.out_y       <= ry;
      res.zero_filled <= zf;
      res.sample_out  <= zf ? '0 : (blend[F +: PIX_W] ^ {1'b1, (PIX_W-1)'(0)});
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import bir_pkg::*;

  localparam int MAX_IN_W    = 64;
  localparam int MAX_IN_H    = 64;
  localparam int MAX_OUT     = 256;
  localparam int FRAC        = 16;
  localparam int SETTLE_CYC  = FRAC + 40;

  // Scoreboard: mirrors the frame store and the size registers, predicts
  // each compute result and checks results in order.
  class resize_scoreboard;
    logic [PIX_W-1:0] pixels [MAX_IN_W*MAX_IN_H];
    bit               written [MAX_IN_W*MAX_IN_H];
    logic [8:0]       sizes [4];
    res_t             pending [$];
    int               errors;

    function new();
      foreach (written[i]) written[i] = 0;
      sizes[REG_IN_WIDTH] = 64;
      sizes[REG_IN_HEIGHT] = 64;
      sizes[REG_OUT_WIDTH] = 64;
      sizes[REG_OUT_HEIGHT] = 64;
      errors = 0;
    endfunction

    function int eff_size(int v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function longint biased(int col, int row);
      return longint'({~pixels[row*MAX_IN_W+col][PIX_W-1], pixels[row*MAX_IN_W+col][PIX_W-2:0]});
    endfunction

    // returns 1 when the request would read an unwritten pixel
    function bit reads_unwritten(req_t r);
      int iw, ih, ow, oh, ix, iy;
      iw = eff_size(sizes[REG_IN_WIDTH], MAX_IN_W);
      ih = eff_size(sizes[REG_IN_HEIGHT], MAX_IN_H);
      ow = eff_size(sizes[REG_OUT_WIDTH], MAX_OUT);
      oh = eff_size(sizes[REG_OUT_HEIGHT], MAX_OUT);
      if (r.action == ACT_LOAD) return 0;
      if (r.coord_x >= ow || r.coord_y >= oh) return 0;
      ix = r.coord_x * iw / ow;
      iy = r.coord_y * ih / oh;
      if (ix + 1 >= iw || iy + 1 >= ih) return 0;
      return !(written[iy*MAX_IN_W+ix] && written[iy*MAX_IN_W+ix+1] &&
               written[(iy+1)*MAX_IN_W+ix] && written[(iy+1)*MAX_IN_W+ix+1]);
    endfunction

    function void note_request(req_t r);
      int iw, ih, ow, oh;
      longint nx, ny, ix, iy, u, t, a, b, hi, lo, w, blend;
      res_t e;
      iw = eff_size(sizes[REG_IN_WIDTH], MAX_IN_W);
      ih = eff_size(sizes[REG_IN_HEIGHT], MAX_IN_H);
      ow = eff_size(sizes[REG_OUT_WIDTH], MAX_OUT);
      oh = eff_size(sizes[REG_OUT_HEIGHT], MAX_OUT);
      w = longint'(1) << FRAC;
      if (r.action == ACT_LOAD) begin
        if (r.coord_x < iw && r.coord_y < ih) begin
          pixels[r.coord_y*MAX_IN_W+r.coord_x] = r.sample_in;
          written[r.coord_y*MAX_IN_W+r.coord_x] = 1;
        end
        return;
      end
      e.out_x = r.coord_x;
      e.out_y = r.coord_y;
      e.sample_out = '0;
      e.zero_filled = 1'b1;
      if (r.coord_x < ow && r.coord_y < oh) begin
        nx = r.coord_x * iw;
        ny = r.coord_y * ih;
        ix = nx / ow;
        iy = ny / oh;
        if (ix + 1 < iw && iy + 1 < ih) begin
          u = ((nx % ow) << FRAC) / ow;
          t = ((ny % oh) << FRAC) / oh;
          a = biased(ix, iy) * (w - u) + biased(ix + 1, iy) * u;
          b = biased(ix, iy + 1) * (w - u) + biased(ix + 1, iy + 1) * u;
          hi = (a >> FRAC) * (w - t) + (b >> FRAC) * t;
          lo = (a & (w - 1)) * (w - t) + (b & (w - 1)) * t + (longint'(1) << (2*FRAC - 1));
          blend = (hi + (lo >> FRAC)) >> FRAC;
          e.sample_out = blend[PIX_W-1:0] ^ 24'h800000;
          e.zero_filled = 1'b0;
        end
      end
      pending.push_back(e);
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with no request outstanding");
        return;
      end
      e = pending.pop_front();
      if (got.sample_out !== e.sample_out)
        report_mismatch($sformatf("(%0d,%0d) sample_out %0d, want %0d",
                                  e.out_x, e.out_y, got.sample_out, e.sample_out));
      if (got.out_x !== e.out_x || got.out_y !== e.out_y)
        report_mismatch($sformatf("coords (%0d,%0d), want (%0d,%0d)",
                                  got.out_x, got.out_y, e.out_x, e.out_y));
      if (got.zero_filled !== e.zero_filled)
        report_mismatch($sformatf("(%0d,%0d) zero_filled %0b, want %0b",
                                  e.out_x, e.out_y, got.zero_filled, e.zero_filled));
    endfunction

    function void report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  req_t        req = '0;
  logic        busy, done;
  res_t        res;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  bit          start_held = 0;

  resize_scoreboard sb = new();

  bilinear_image_resizer dut (
    .clk, .rst, .start, .req, .busy, .done, .res,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial forever #1 clk = ~clk;

  // results are a strobe: check on every edge where done is high
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(res);
  end

  // drop start before any idle edge; back-to-back requests keep it high
  task automatic release_start();
    if (start_held) begin
      start <= 0;
      start_held = 0;
    end
  endtask

  task automatic idle_cycles(int n);
    release_start();
    repeat (n) @(posedge clk);
  endtask

  // mostly short gaps, a few long ones, sometimes none at all
  task automatic random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return;
    else if (r < 93) idle_cycles($urandom_range(1, 3));
    else idle_cycles($urandom_range(10, 60));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    @(posedge clk);
    sb.sizes[idx] = (idx == REG_IN_WIDTH || idx == REG_IN_HEIGHT) ? value[6:0] : value[8:0];
  endtask

  // hold start until the block takes the request at an edge with busy low
  task automatic send_request(req_t r);
    if (sb.reads_unwritten(r)) return;
    req <= r;
    if (!start_held) begin
      start <= 1;
      start_held = 1;
    end
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(r);
  endtask

  // wait until every result is in, then let a possible load finish
  task automatic drain();
    release_start();
    while (sb.pending.size() != 0) @(posedge clk);
    idle_cycles(SETTLE_CYC);
  endtask

  task automatic set_sizes(int iw, int ih, int ow, int oh);
    drain();
    write_reg(REG_IN_WIDTH, iw);
    write_reg(REG_IN_HEIGHT, ih);
    write_reg(REG_OUT_WIDTH, ow);
    write_reg(REG_OUT_HEIGHT, oh);
  endtask

  function automatic req_t make_req(logic act, int x, int y, logic [PIX_W-1:0] v);
    req_t r;
    r.action = act;
    r.coord_x = COORD_W'(x);
    r.coord_y = COORD_W'(y);
    r.sample_in = v;
    return r;
  endfunction

  task automatic load_frame(int iw, int ih);
    logic [PIX_W-1:0] v;
    for (int y = 0; y < ih; y++)
      for (int x = 0; x < iw; x++) begin
        case ($urandom_range(0, 5))
          0: v = 24'h7FFFFF;
          1: v = 24'h800000;
          default: v = PIX_W'($urandom());
        endcase
        send_request(make_req(ACT_LOAD, x, y, v));
      end
  endtask

  task automatic random_phase(int iw, int ih, int ow, int oh, int count);
    req_t r;
    int pick;
    set_sizes(iw, ih, ow, oh);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15)
        r = make_req(ACT_LOAD, $urandom_range(0, 255), $urandom_range(0, 255),
                     PIX_W'($urandom()));
      else if (pick < 25)
        r = make_req(ACT_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
                     PIX_W'($urandom()));
      else if (pick < 85)
        r = make_req(ACT_COMPUTE, $urandom_range(0, ow), $urandom_range(0, oh),
                     PIX_W'($urandom()));
      else
        r = make_req(ACT_COMPUTE, $urandom_range(0, 255), $urandom_range(0, 255),
                     PIX_W'($urandom()));
      send_request(r);
      random_gap();
    end
  endtask

  initial begin
    idle_cycles(5);
    rst <= 0;
    @(posedge clk);

    // directed: two full-width rows and a 16x16 corner at reset sizes,
    // then corner and border requests
    load_frame(64, 2);
    load_frame(16, 16);
    send_request(make_req(ACT_COMPUTE, 0, 0, 24'hFFFFFF));
    send_request(make_req(ACT_COMPUTE, 14, 14, 0));
    send_request(make_req(ACT_COMPUTE, 63, 0, 0));        // neighbor past last column
    send_request(make_req(ACT_COMPUTE, 0, 63, 0));        // neighbor past last row
    send_request(make_req(ACT_COMPUTE, 64, 5, 0));        // outside output width
    send_request(make_req(ACT_COMPUTE, 255, 255, 0));
    send_request(make_req(ACT_LOAD, 200, 3, 24'h123456)); // load outside source: ignored
    send_request(make_req(ACT_LOAD, 3, 64, 24'h7FFFFF));
    send_request(make_req(ACT_COMPUTE, 3, 3, 0));

    // zero sizes act as one; oversized saturate
    set_sizes(0, 0, 0, 0);
    send_request(make_req(ACT_COMPUTE, 0, 0, 0));
    send_request(make_req(ACT_COMPUTE, 1, 0, 0));
    set_sizes(127, 127, 511, 511);
    send_request(make_req(ACT_COMPUTE, 0, 0, 0));
    send_request(make_req(ACT_COMPUTE, 62, 2, 0));
    send_request(make_req(ACT_COMPUTE, 255, 0, 0));
    set_sizes(2, 2, 256, 256);
    send_request(make_req(ACT_COMPUTE, 127, 127, 0));
    send_request(make_req(ACT_COMPUTE, 128, 0, 0));
    set_sizes(64, 64, 1, 1);
    send_request(make_req(ACT_COMPUTE, 0, 0, 0));

    // random phases over several shapes, including the extremes
    random_phase(16, 16, 64, 64, 130);
    random_phase(16, 16, 256, 256, 130);
    random_phase(2, 2, 255, 7, 120);
    random_phase(16, 16, 33, 200, 150);
    random_phase(64, 2, 100, 100, 100);
    random_phase(1, 16, 1, 256, 80);
    random_phase($urandom_range(1, 16), $urandom_range(1, 16),
                 $urandom_range(1, 256), $urandom_range(1, 256), 150);
    random_phase(16, 16, 13, 250, 120);

    // sender pauses until everything is back
    drain();
    random_phase(12, 12, 96, 48, 80);

    drain();
    if (sb.errors == 0) $display("bilinear_image_resizer test passed");
    else $display("bilinear_image_resizer test failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("bilinear_image_resizer test failed");
    $finish;
  end

endmodule
